@@ hw/rtl/ptb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the periodic timer bank.
// No dependencies; imported by ptb_order and periodic_timer_bank_core.
package ptb_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int IDX_W      = $clog2(NUM_TIMERS);
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

    localparam logic [3:0] OP_TICK       = 4'd0;
    localparam logic [3:0] OP_CREATE     = 4'd1;
    localparam logic [3:0] OP_DELETE     = 4'd2;
    localparam logic [3:0] OP_PAUSE      = 4'd3;
    localparam logic [3:0] OP_RESUME     = 4'd4;
    localparam logic [3:0] OP_READY      = 4'd5;
    localparam logic [3:0] OP_RESTART    = 4'd6;
    localparam logic [3:0] OP_SET_PERIOD = 4'd7;
    localparam logic [3:0] OP_SET_REPEAT = 4'd8;

    localparam logic [1:0] KIND_EVENT   = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [1:0] FIN_RUNNING = 2'd0;
    localparam logic [1:0] FIN_PAUSED  = 2'd1;
    localparam logic [1:0] FIN_DELETED = 2'd2;

    localparam logic [15:0] REPEAT_FOREVER = 16'hFFFF;

    typedef struct packed {
        logic             append;
        logic             remove;
        logic [IDX_W-1:0] slot;
    } ord_cmd_t;

    typedef struct packed {
        logic [31:0] period;
        logic [31:0] run_stamp;
        logic [15:0] repeats;
    } timer_ent_t;

endpackage

@@ hw/rtl/ptb_order.sv @@
`timescale 1ns / 1ps
// Creation-order list of live timer slots with append and compacting remove.
// Depends on ptb_pkg.
module ptb_order
    import ptb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ord_cmd_t         cmd,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [IDX_W-1:0] rd_slot,
    output logic [CNT_W-1:0] count
);

    logic [IDX_W-1:0] order_reg  [NUM_TIMERS];
    logic [IDX_W-1:0] order_next [NUM_TIMERS];
    logic [IDX_W-1:0] order_sh   [NUM_TIMERS];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [NUM_TIMERS-1:0] hit;
    logic [NUM_TIMERS-1:0] shift;

    always_comb
    begin
        for (int j = 0; j < NUM_TIMERS; j++)
        begin
            hit[j] = (CNT_W'(j) < count_reg) && (order_reg[j] == cmd.slot);
        end
        shift[0] = hit[0];
        for (int j = 1; j < NUM_TIMERS; j++)
        begin
            shift[j] = shift[j-1] | hit[j];
        end
        for (int j = 0; j < NUM_TIMERS - 1; j++)
        begin
            order_sh[j] = order_reg[j+1];
        end
        order_sh[NUM_TIMERS-1] = order_reg[NUM_TIMERS-1];

        for (int j = 0; j < NUM_TIMERS; j++)
        begin
            order_next[j] = (cmd.remove && shift[j]) ? order_sh[j] : order_reg[j];
        end
        count_next = count_reg;
        if (cmd.remove && (|hit))
        begin
            count_next = count_reg - 1'b1;
        end
        else if (cmd.append && (count_reg < CNT_W'(NUM_TIMERS)))
        begin
            order_next[count_reg[IDX_W-1:0]] = cmd.slot;
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NUM_TIMERS; j++)
        begin
            order_reg[j] <= order_next[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign rd_slot = order_reg[rd_idx];
    assign count   = count_reg;

endmodule

@@ hw/rtl/periodic_timer_bank_core.sv @@
`timescale 1ns / 1ps
// Periodic timer bank: command decoder, tick walker and per-slot timer memory.
// Depends on ptb_pkg and ptb_order.
//
// Each timer's period, last run time and repeat count sit in one single-port
// synchronous memory word, read through a registered output and written back.
// A command other than tick goes on to the response state, which registers
// its result, passing a modify state first if it modifies the memory word
// (ready, restart, set period, set repeat). A tick walks the live timers in
// creation order, skipping paused ones: each is read, its elapsed time taken
// and it is evaluated. A summary pass reads each again, takes its elapsed and
// remaining time and keeps the minimum; a deletion cuts the walk short. The
// memory is read once per visited timer in each pass. Output backpressure
// stalls the walk. Input is taken only between commands.
module periodic_timer_bank_core
    import ptb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        auto_delete,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  op,
    input  logic [3:0]  slot,
    input  logic [31:0] period_value,
    input  logic signed [15:0] repeat_value,
    input  logic [31:0] now,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [3:0]  slot_res,
    output logic        fired,
    output logic [1:0]  finished,
    output logic [31:0] next_due,
    output logic        last
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CMOD, ST_RESP,
        ST_WRD, ST_WEL, ST_WEVAL,
        ST_SRD, ST_SEL, ST_SREM, ST_SMIN
    } state_t;

    state_t state_reg, state_next;

    timer_ent_t mem [NUM_TIMERS];
    timer_ent_t rd_data_reg;
    logic             rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    timer_ent_t       wr_data;

    logic [NUM_TIMERS-1:0] used_reg, used_next;
    logic [NUM_TIMERS-1:0] paused_reg, paused_next;
    logic auto_del_reg;

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [3:0]  op_reg, op_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] per_in_reg, per_in_next;
    logic [15:0] rep_in_reg, rep_in_next;
    logic [31:0] el_reg, el_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] best_reg, best_next;
    logic [1:0]  resp_kind_reg, resp_kind_next;
    logic [3:0]  resp_slot_reg, resp_slot_next;

    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [3:0]  slot_res_reg;
    logic        fired_reg;
    logic [1:0]  fin_reg;
    logic [31:0] due_reg;
    logic        last_reg;

    logic        emit;
    logic [1:0]  e_kind;
    logic [3:0]  e_slot;
    logic        e_fired;
    logic [1:0]  e_fin;
    logic [31:0] e_due;
    logic        e_last;
    logic        out_free;

    ord_cmd_t         ord_cmd;
    logic [IDX_W-1:0] ord_slot;
    logic [CNT_W-1:0] ord_count;

    logic [IDX_W-1:0] free_slot;
    logic             free_found;
    logic [IDX_W-1:0] in_slot;
    logic             slot_ok;

    logic        due;
    logic        dec;
    logic [15:0] new_rep;
    logic        fin_any;
    logic        has_event;

    ptb_order u_order (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ord_cmd),
        .rd_idx  (idx_reg[IDX_W-1:0]),
        .rd_slot (ord_slot),
        .count   (ord_count)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_slot   = slot[IDX_W-1:0];
    assign slot_ok   = ({1'b0, slot} < 5'(NUM_TIMERS)) && used_reg[in_slot];

    always_comb
    begin
        free_slot  = '0;
        free_found = 1'b0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot  = IDX_W'(i);
                free_found = 1'b1;
            end
        end
    end

    // walk evaluation on the entry read for cur_reg
    always_comb
    begin
        due       = el_reg >= rd_data_reg.period;
        dec       = due && (rd_data_reg.repeats != 16'd0) && !rd_data_reg.repeats[15];
        new_rep   = dec ? rd_data_reg.repeats - 16'd1 : rd_data_reg.repeats;
        fin_any   = (new_rep == 16'd0);
        has_event = due || fin_any;
    end

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        paused_next    = paused_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        op_next        = op_reg;
        now_next       = now_reg;
        per_in_next    = per_in_reg;
        rep_in_next    = rep_in_reg;
        el_next        = el_reg;
        rem_next       = rem_reg;
        best_next      = best_reg;
        resp_kind_next = resp_kind_reg;
        resp_slot_next = resp_slot_reg;
        rd_en   = 1'b0;
        rd_addr = cur_reg;
        wr_en   = 1'b0;
        wr_addr = cur_reg;
        wr_data = rd_data_reg;
        ord_cmd = '{append: 1'b0, remove: 1'b0, slot: cur_reg};
        emit    = 1'b0;
        e_kind  = KIND_EVENT;
        e_slot  = '0;
        e_fired = 1'b0;
        e_fin   = FIN_RUNNING;
        e_due   = '0;
        e_last  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next        = op;
                    now_next       = now;
                    per_in_next    = period_value;
                    rep_in_next    = repeat_value;
                    cur_next       = in_slot;
                    resp_kind_next = KIND_DONE;
                    resp_slot_next = '0;
                    state_next     = ST_RESP;
                    if (op == OP_TICK)
                    begin
                        idx_next   = '0;
                        state_next = ST_WRD;
                    end
                    else if (op == OP_CREATE)
                    begin
                        if ((ord_count >= CNT_W'(NUM_TIMERS)) || !free_found)
                        begin
                            resp_kind_next = KIND_ERROR;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = free_slot;
                            wr_data = '{period: period_value, run_stamp: now,
                                        repeats: REPEAT_FOREVER};
                            used_next[free_slot]   = 1'b1;
                            paused_next[free_slot] = 1'b0;
                            ord_cmd = '{append: 1'b1, remove: 1'b0, slot: free_slot};
                            resp_slot_next = 4'(free_slot);
                        end
                    end
                    else if ((op > OP_SET_REPEAT) || !slot_ok)
                    begin
                        resp_kind_next = KIND_ERROR;
                    end
                    else if (op == OP_DELETE)
                    begin
                        ord_cmd = '{append: 1'b0, remove: 1'b1, slot: in_slot};
                        used_next[in_slot]   = 1'b0;
                        paused_next[in_slot] = 1'b0;
                    end
                    else if (op == OP_PAUSE)
                    begin
                        paused_next[in_slot] = 1'b1;
                    end
                    else if (op == OP_RESUME)
                    begin
                        paused_next[in_slot] = 1'b0;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = in_slot;
                        state_next = ST_CMOD;
                    end
                end
            end

            ST_CMOD:
            begin
                wr_en = 1'b1;
                priority if (op_reg == OP_READY)
                    wr_data.run_stamp = now_reg + ~rd_data_reg.period;
                else if (op_reg == OP_RESTART)
                    wr_data.run_stamp = now_reg;
                else if (op_reg == OP_SET_PERIOD)
                    wr_data.period = per_in_reg;
                else
                    wr_data.repeats = rep_in_reg;
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_kind     = resp_kind_reg;
                    e_slot     = resp_slot_reg;
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_WRD:
            begin
                if (idx_reg >= ord_count)
                begin
                    idx_next   = '0;
                    best_next  = '1;
                    state_next = ST_SRD;
                end
                else if (paused_reg[ord_slot])
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ord_slot;
                    cur_next   = ord_slot;
                    state_next = ST_WEL;
                end
            end

            ST_WEL:
            begin
                el_next    = now_reg - rd_data_reg.run_stamp;
                state_next = ST_WEVAL;
            end

            ST_WEVAL:
            begin
                if (!has_event || out_free)
                begin
                    if (due)
                    begin
                        wr_en   = 1'b1;
                        wr_data = '{period: rd_data_reg.period, run_stamp: now_reg,
                                    repeats: new_rep};
                    end
                    if (has_event)
                    begin
                        emit    = 1'b1;
                        e_kind  = KIND_EVENT;
                        e_slot  = 4'(cur_reg);
                        e_fired = due && (rd_data_reg.repeats != 16'd0);
                        e_fin   = !fin_any ? FIN_RUNNING
                                : (auto_del_reg ? FIN_DELETED : FIN_PAUSED);
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_WRD;
                    if (fin_any)
                    begin
                        if (auto_del_reg)
                        begin
                            ord_cmd = '{append: 1'b0, remove: 1'b1, slot: cur_reg};
                            used_next[cur_reg]   = 1'b0;
                            paused_next[cur_reg] = 1'b0;
                            idx_next   = '0;
                            best_next  = '1;
                            state_next = ST_SRD;
                        end
                        else
                        begin
                            paused_next[cur_reg] = 1'b1;
                        end
                    end
                end
            end

            ST_SRD:
            begin
                if (idx_reg >= ord_count)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        e_kind     = KIND_SUMMARY;
                        e_due      = best_reg;
                        e_last     = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (paused_reg[ord_slot])
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ord_slot;
                    state_next = ST_SEL;
                end
            end

            ST_SEL:
            begin
                el_next    = now_reg - rd_data_reg.run_stamp;
                state_next = ST_SREM;
            end

            ST_SREM:
            begin
                rem_next   = (el_reg >= rd_data_reg.period) ? 32'd0
                           : rd_data_reg.period - el_reg;
                state_next = ST_SMIN;
            end

            ST_SMIN:
            begin
                if (rem_reg < best_reg)
                begin
                    best_next = rem_reg;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = ST_SRD;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // timer memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            paused_reg    <= '0;
            auto_del_reg  <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            paused_reg <= paused_next;
            idx_reg    <= idx_next;
            if (cfg_valid)
            begin
                auto_del_reg <= auto_delete;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        op_reg        <= op_next;
        now_reg       <= now_next;
        per_in_reg    <= per_in_next;
        rep_in_reg    <= rep_in_next;
        el_reg        <= el_next;
        rem_reg       <= rem_next;
        best_reg      <= best_next;
        resp_kind_reg <= resp_kind_next;
        resp_slot_reg <= resp_slot_next;
        if (emit)
        begin
            kind_reg     <= e_kind;
            slot_res_reg <= e_slot;
            fired_reg    <= e_fired;
            fin_reg      <= e_fin;
            due_reg      <= e_due;
            last_reg     <= e_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign slot_res  = slot_res_reg;
    assign fired     = fired_reg;
    assign finished  = fin_reg;
    assign next_due  = due_reg;
    assign last      = last_reg;

endmodule
